[rtl/core/bdf_pkg.sv]
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types, codes and helper functions of the advertiser address
// duplicate filter: command and result payloads, the probe token that walks
// the cell chain, and the tracker classification.
// ----------------------------------------------------------------------------
package bdf_pkg;

	localparam int DefTableDepth = 64;
	localparam int AddrW         = 48;
	localparam int CountW        = 7;

	// manufacturer and service byte patterns used for tracker classification
	localparam logic [7:0] MfgOfB0    = 8'h4C;
	localparam logic [7:0] MfgOfB2    = 8'h12;
	localparam logic [7:0] CidALo     = 8'h67;
	localparam logic [7:0] CidBLo     = 8'hE6;
	localparam logic [7:0] CidBHi     = 8'h07;
	localparam logic [7:0] SvcUuidLo  = 8'h5A;
	localparam logic [7:0] SvcUuidHi  = 8'hFD;
	localparam logic [7:0] ZeroByte   = 8'h00;
	localparam logic [7:0] MfgLenOf   = 8'd4;
	localparam logic [7:0] MfgLenCid  = 8'd2;
	localparam logic [7:0] SvcLenMin  = 8'd2;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_REPORT   = 2'd1,
		OP_COMPLETE = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic {
		KIND_DEVICE = 1'b0,
		KIND_DONE   = 1'b1
	} kind_t;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_TRUNCATED = 1'b1
	} status_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_SEARCH = 1'b1
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [AddrW-1:0]  address;
		logic [1:0]        addr_kind;
		logic signed [7:0] rssi;
		logic [7:0]        mfg_len;
		logic [31:0]       mfg_head;
		logic [7:0]        svc_len;
		logic [15:0]       svc_uuid;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [AddrW-1:0]  device_address;
		logic [1:0]        device_addr_kind;
		logic signed [7:0] device_rssi;
		logic [3:0]        tag_bits;
		logic [CountW-1:0] device_count;
		logic [31:0]       elapsed_ms;
		status_t           status;
		logic [7:0]        sequence_res;
	} res_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [AddrW-1:0] key;
	} probe_t;

	// received byte order to display order
	function automatic logic [AddrW-1:0] swap_addr(input logic [AddrW-1:0] a);
		return {a[7:0], a[15:8], a[23:16], a[31:24], a[39:32], a[47:40]};
	endfunction

	function automatic logic [3:0] tracker_class(
		input logic [7:0]  mfg_len,
		input logic [31:0] mfg_head,
		input logic [7:0]  svc_len,
		input logic [15:0] svc_uuid
	);
		logic [3:0] f;
		f    = '0;
		f[0] = (mfg_len >= MfgLenOf) && (mfg_head[7:0] == MfgOfB0) &&
		       (mfg_head[15:8] == ZeroByte) && (mfg_head[23:16] == MfgOfB2);
		f[1] = (svc_len >= SvcLenMin) && (svc_uuid[7:0] == SvcUuidLo) &&
		       (svc_uuid[15:8] == SvcUuidHi);
		f[2] = (mfg_len >= MfgLenCid) && (mfg_head[7:0] == CidALo) &&
		       (mfg_head[15:8] == ZeroByte);
		f[3] = (mfg_len >= MfgLenCid) && (mfg_head[7:0] == CidBLo) &&
		       (mfg_head[15:8] == CidBHi);
		return f;
	endfunction

endpackage

[rtl/core/bdf_cell.sv]
// ----------------------------------------------------------------------------
// bdf_cell
// One address cell: holds one table entry, compares the passing probe token
// against it and hands the token on. On insert the entry moves to the next
// cell and takes its neighbor's entry.
// ----------------------------------------------------------------------------
module bdf_cell
	import bdf_pkg::*;
#(
	parameter int CW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [AddrW-1:0] ent_in,
	output logic [AddrW-1:0] ent_out,
	input  probe_t           probe_in,
	input  logic [CW-1:0]    live_in,
	output probe_t           probe_out,
	output logic [CW-1:0]    live_out
);

	logic [AddrW-1:0] entry_q;
	probe_t           probe_q;
	logic [CW-1:0]    live_q;
	logic             occupied;
	logic             match;

	// entries stay packed from the head, so a nonzero remaining count marks
	// this cell as holding a written address
	assign occupied = (live_in != '0);
	assign match    = probe_in.vld && occupied && (probe_in.key == entry_q);

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
			live_q  <= '0;
		end else begin
			probe_q <= '{vld: probe_in.vld, hit: probe_in.hit | match, key: probe_in.key};
			live_q  <= live_in - CW'(occupied);
		end
	end

	assign ent_out   = entry_q;
	assign probe_out = probe_q;
	assign live_out  = live_q;

endmodule

[rtl/core/ble_address_dedup_filter_core.sv]
// ----------------------------------------------------------------------------
// ble_address_dedup_filter_core
// Duplicate filter for one scan session of advertiser reports. Addresses are
// kept in a chain of cells; a report's address walks the chain as a token
// and a new address is shifted in at the head while the table has room.
//
//   channel  handshake     payload  transfer
//   command  start, busy   cmd_t    rising edge with start && !busy
//   result   strobe        res_t    the one cycle strobe is high, no stall
//
// start, tick and complete never raise busy; a complete result shows on the
// next cycle. A report in an open session holds busy while its token passes
// the inject stage and then each cell in turn, and no new command is taken
// until busy drops; its result, if any, shows as busy drops. A report with
// no open session does not raise busy. Reset clears counters, session and
// sequence; table cells are never read past the fill count.
// ----------------------------------------------------------------------------
module ble_address_dedup_filter_core
	import bdf_pkg::*;
#(
	parameter int TABLE_DEPTH = DefTableDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic strobe,
	output res_t result
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t            state_q, nxt_state;
	logic              session_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     nxt_count;
	logic [31:0]       timer_q;
	logic [7:0]        seq_q;
	logic              strobe_q;
	logic              inj_vld_q;
	logic [AddrW-1:0]  key_q;
	logic [1:0]        type_q;
	logic signed [7:0] rssi_q;
	logic [3:0]        flags_q;
	res_t              result_q;
	res_t              res_d;

	logic              accept;
	logic              launch;
	logic              fin;
	logic              full;
	logic              ins;
	logic              trunc;
	logic              emit;

	probe_t            probe_c [0:TABLE_DEPTH];
	logic [CW-1:0]     live_c  [0:TABLE_DEPTH];
	logic [AddrW-1:0]  ent_c   [0:TABLE_DEPTH];

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign full      = (count_q >= CW'(TABLE_DEPTH));
	assign nxt_count = count_q + CW'(1);
	assign ins       = fin && !probe_c[TABLE_DEPTH].hit && !full;
	assign trunc     = fin && !probe_c[TABLE_DEPTH].hit && full;

	assign probe_c[0] = '{vld: inj_vld_q, hit: 1'b0, key: key_q};
	assign live_c[0]  = count_q;
	assign ent_c[0]   = key_q;

	// cell chain
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		bdf_cell #(.CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (ins),
			.ent_in   (ent_c[k]),
			.ent_out  (ent_c[k+1]),
			.probe_in (probe_c[k]),
			.live_in  (live_c[k]),
			.probe_out(probe_c[k+1]),
			.live_out (live_c[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state = state_q;
		launch    = 1'b0;
		fin       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.operation == OP_REPORT) && session_q) begin
					launch    = 1'b1;
					nxt_state = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				// token left the last cell
				if (probe_c[TABLE_DEPTH].vld) begin
					fin       = 1'b1;
					nxt_state = ST_IDLE;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	// result payload for this cycle, if any
	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		if (accept && (cmd.operation == OP_COMPLETE)) begin
			emit               = 1'b1;
			res_d.kind         = KIND_DONE;
			res_d.device_count = CountW'(count_q);
			res_d.elapsed_ms   = timer_q;
			res_d.status       = STATUS_OK;
		end
		if (ins) begin
			emit                   = 1'b1;
			res_d.kind             = KIND_DEVICE;
			res_d.device_address   = key_q;
			res_d.device_addr_kind = type_q;
			res_d.device_rssi      = rssi_q;
			res_d.tag_bits         = flags_q;
			res_d.device_count     = CountW'(nxt_count);
		end
		if (trunc) begin
			emit               = 1'b1;
			res_d.kind         = KIND_DONE;
			res_d.device_count = CountW'(count_q);
			res_d.elapsed_ms   = timer_q;
			res_d.status       = STATUS_TRUNCATED;
		end
		res_d.sequence_res = seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 1'b0;
			count_q   <= '0;
			timer_q   <= '0;
			seq_q     <= '0;
			strobe_q  <= 1'b0;
			inj_vld_q <= 1'b0;
		end else begin
			strobe_q  <= emit;
			inj_vld_q <= launch;
			if (emit) begin
				seq_q <= seq_q + 8'd1;
			end
			if (accept) begin
				case (cmd.operation)
					OP_START: begin
						if (!session_q) begin
							session_q <= 1'b1;
							timer_q   <= '0;
							count_q   <= '0;
						end
					end
					OP_COMPLETE: begin
						session_q <= 1'b0;
					end
					OP_TICK: begin
						timer_q <= timer_q + 32'd1;
					end
					default: begin
					end
				endcase
			end
			if (ins) begin
				count_q <= nxt_count;
			end
			if (trunc) begin
				session_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			key_q   <= swap_addr(cmd.address);
			type_q  <= cmd.addr_kind;
			rssi_q  <= cmd.rssi;
			flags_q <= tracker_class(cmd.mfg_len, cmd.mfg_head, cmd.svc_len, cmd.svc_uuid);
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
